// ===== design/tsm_pkg.sv =====
// ============================================================================
// tsm_pkg
// Shared types and constants of the trie substring matcher: item codes,
// result record, control bundles and default sizes.
// ============================================================================
package tsm_pkg;

   // Default sizes of the node table, the alphabet and the longest pattern.
   localparam int NODES_DEFAULT    = 1024;
   localparam int ALPHABET_DEFAULT = 128;
   localparam int MAX_WORD_DEFAULT = 32;

   // Fixed widths of the channel fields.
   localparam int CHAR_BITS   = 7;
   localparam int STATUS_BITS = 2;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_SEARCH = 1'b1
   } tsm_op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_TOO_LONG = 2'd2
   } tsm_status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_INSERT,
      S_SEARCH,
      S_REPORT
   } tsm_state_type;

   typedef struct packed {
      logic           matched;
      tsm_status_type status;
      logic           end_of_item;
   } tsm_result_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } tsm_link_ctl_type;

endpackage

// ===== design/tsm_if.sv =====
// ============================================================================
// tsm_if
// Valid/ready channels of the matcher: the request channel carries one
// pattern or text character, the response channel one result.
// ============================================================================
interface tsm_req_if import tsm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 opcode;
   logic [CHAR_BITS-1:0] character;
   logic                 last;

   modport source (output valid, output opcode, output character, output last,
                   input ready);
   modport sink (input valid, input opcode, input character, input last,
                 output ready);
endinterface

interface tsm_rsp_if import tsm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   matched;
   logic [STATUS_BITS-1:0] status;
   logic                   end_of_item;

   modport source (output valid, output matched, output status, output end_of_item,
                   input ready);
   modport sink (input valid, input matched, input status, input end_of_item,
                 output ready);
endinterface

// ===== design/tsm_link_store.sv =====
// ============================================================================
// tsm_link_store
// Child link memory of the trie. Each entry holds the child node index and
// the end mark of that child. After reset the memory is swept to zero.
// ============================================================================
module tsm_link_store import tsm_pkg::*; #(
   parameter int NODES    = NODES_DEFAULT,
   parameter int ALPHABET = ALPHABET_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  tsm_link_ctl_type                              ctl,
   input  logic [$clog2(NODES)+$clog2(ALPHABET)-1:0]     rd_addr,
   input  logic [$clog2(NODES)+$clog2(ALPHABET)-1:0]     wr_addr,
   input  logic [$clog2(NODES):0]                        wr_data,
   output logic [$clog2(NODES):0]                        rd_data,
   output logic                                          clear_busy
);

   localparam int NODE_W     = $clog2(NODES);
   localparam int CHAR_W     = $clog2(ALPHABET);
   localparam int LA_W       = NODE_W + CHAR_W;
   localparam int LINK_DEPTH = NODES * (2 ** CHAR_W);

   logic [NODE_W:0]   link_mem [LINK_DEPTH];
   logic [NODE_W:0]   rd_data_ff;
   logic [LA_W-1:0]   sweep_ff, sweep_in;
   logic              busy_ff, busy_in;
   logic              mem_wr_en;
   logic [LA_W-1:0]   mem_wr_addr;
   logic [NODE_W:0]   mem_wr_data;

   always_comb begin
      sweep_in = sweep_ff;
      busy_in  = busy_ff;
      if (busy_ff) begin
         sweep_in = sweep_ff + LA_W'(1);
         if (sweep_ff == LA_W'(LINK_DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         busy_ff  <= 1'b1;
      end else begin
         sweep_ff <= sweep_in;
         busy_ff  <= busy_in;
      end
   end

   // The clearing sweep owns the write port until it has covered every entry.
   assign mem_wr_en   = busy_ff || ctl.wr_en;
   assign mem_wr_addr = busy_ff ? sweep_ff : wr_addr;
   assign mem_wr_data = busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         link_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= link_mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = busy_ff;

endmodule

// ===== design/tsm_ctrl.sv =====
// ============================================================================
// tsm_ctrl
// Item sequencer: walks the insert cursor for pattern characters and runs
// the partial-match list through the link memory for text characters.
// ============================================================================
module tsm_ctrl import tsm_pkg::*; #(
   parameter int NODES    = NODES_DEFAULT,
   parameter int ALPHABET = ALPHABET_DEFAULT,
   parameter int MAX_WORD = MAX_WORD_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   input  logic                                          req_opcode,
   input  logic [CHAR_BITS-1:0]                          req_character,
   input  logic                                          req_last,
   output logic                                          req_ready,
   input  logic                                          out_free,
   output logic                                          done,
   output tsm_result_type                                result,
   output tsm_link_ctl_type                              link_ctl,
   output logic [$clog2(NODES)+$clog2(ALPHABET)-1:0]     link_rd_addr,
   output logic [$clog2(NODES)+$clog2(ALPHABET)-1:0]     link_wr_addr,
   output logic [$clog2(NODES):0]                        link_wr_data,
   input  logic [$clog2(NODES):0]                        link_rd_data,
   input  logic                                          clear_busy
);

   localparam int NODE_W = $clog2(NODES);
   localparam int CHAR_W = $clog2(ALPHABET);
   localparam int CNT_W  = $clog2(MAX_WORD + 1);
   localparam int IDX_W  = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

   tsm_state_type          state_ff, state_in;
   logic [CHAR_BITS-1:0]   char_ff, char_in;
   logic                   last_ff, last_in;
   tsm_result_type         result_ff, result_in;

   // Insert walk.
   logic [NODE_W-1:0]      cursor_ff, cursor_in;
   logic [CNT_W-1:0]       length_ff, length_in;
   logic                   rejected_ff, rejected_in;
   tsm_status_type         code_ff, code_in;
   logic [NODE_W:0]        nodes_used_ff, nodes_used_in;

   // Search walk.
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   match_ff, match_in;
   logic [CNT_W-1:0]       issue_ff, issue_in;
   logic                   issue_done_ff, issue_done_in;
   logic [CNT_W-1:0]       wr_cnt_ff, wr_cnt_in;
   logic                   a_valid_ff, a_valid_in;
   logic                   a_root_ff, a_root_in;
   logic                   b_valid_ff, b_valid_in;

   // Partial-match list memory.
   logic [NODE_W-1:0]      act_mem [MAX_WORD];
   logic [NODE_W-1:0]      act_rdata_ff;
   logic                   act_rd_en;
   logic [IDX_W-1:0]       act_rd_addr;
   logic                   act_wr_en;
   logic [IDX_W-1:0]       act_wr_addr;
   logic [NODE_W-1:0]      act_wr_data;

   logic                   accept;
   logic                   in_alpha;
   logic                   srch_finish;
   logic [NODE_W-1:0]      link_child;
   logic                   link_end;

   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign in_alpha    = (9'(char_ff) < 9'(ALPHABET));
   assign srch_finish = issue_done_ff && !a_valid_ff && !b_valid_ff;
   assign link_child  = link_rd_data[NODE_W-1:0];
   assign link_end    = link_rd_data[NODE_W];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (!clear_busy) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = (tsm_op_type'(req_opcode) == OP_SEARCH) ? S_SEARCH : S_INSERT;
            end
         end
         S_INSERT: begin
            state_in = S_REPORT;
         end
         S_SEARCH: begin
            if (srch_finish) state_in = S_REPORT;
         end
         S_REPORT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      logic [NODE_W-1:0] nxt;
      logic              rej;
      tsm_status_type    code;

      char_in       = char_ff;
      last_in       = last_ff;
      result_in     = result_ff;
      cursor_in     = cursor_ff;
      length_in     = length_ff;
      rejected_in   = rejected_ff;
      code_in       = code_ff;
      nodes_used_in = nodes_used_ff;
      count_in      = count_ff;
      match_in      = match_ff;
      issue_in      = issue_ff;
      issue_done_in = issue_done_ff;
      wr_cnt_in     = wr_cnt_ff;
      a_valid_in    = 1'b0;
      a_root_in     = a_root_ff;
      b_valid_in    = 1'b0;
      link_ctl      = '0;
      link_rd_addr  = {(a_root_ff ? {NODE_W{1'b0}} : act_rdata_ff), CHAR_W'(char_ff)};
      link_wr_addr  = {cursor_ff, CHAR_W'(char_ff)};
      link_wr_data  = '0;
      act_rd_en     = 1'b0;
      act_rd_addr   = issue_ff[IDX_W-1:0];
      act_wr_en     = 1'b0;
      act_wr_addr   = wr_cnt_ff[IDX_W-1:0];
      act_wr_data   = link_child;
      done          = 1'b0;
      nxt           = link_child;
      rej           = rejected_ff;
      code          = code_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               char_in       = req_character;
               last_in       = req_last;
               issue_in      = '0;
               issue_done_in = 1'b0;
               wr_cnt_in     = '0;
               if (tsm_op_type'(req_opcode) == OP_INSERT) begin
                  link_ctl.rd_en = 1'b1;
                  link_rd_addr   = {cursor_ff, CHAR_W'(req_character)};
               end
            end
         end
         S_INSERT: begin
            if (!rejected_ff) begin
               if (length_ff >= CNT_W'(MAX_WORD)) begin
                  rej  = 1'b1;
                  code = STAT_TOO_LONG;
               end else if (!in_alpha) begin
                  rej  = 1'b1;
                  code = STAT_FULL;
               end else if (link_child == '0) begin
                  if (nodes_used_ff >= (NODE_W+1)'(NODES)) begin
                     rej  = 1'b1;
                     code = STAT_FULL;
                  end else begin
                     nxt            = nodes_used_ff[NODE_W-1:0];
                     nodes_used_in  = nodes_used_ff + (NODE_W+1)'(1);
                     link_ctl.wr_en = 1'b1;
                     link_wr_data   = {last_ff, nodes_used_ff[NODE_W-1:0]};
                  end
               end else if (last_ff) begin
                  // Existing node becomes a pattern end: set its mark in place.
                  link_ctl.wr_en = 1'b1;
                  link_wr_data   = {1'b1, link_child};
               end
               if (!rej) begin
                  cursor_in = nxt;
                  length_in = length_ff + CNT_W'(1);
               end
            end
            rejected_in           = rej;
            code_in               = code;
            result_in.matched     = 1'b0;
            result_in.status      = rej ? code : STAT_OK;
            result_in.end_of_item = last_ff;
            if (last_ff) begin
               cursor_in   = '0;
               length_in   = '0;
               rejected_in = 1'b0;
               code_in     = STAT_OK;
            end
         end
         S_SEARCH: begin
            // Stage a: fetch the next partial match, then a token for the root.
            if (!issue_done_ff) begin
               a_valid_in = 1'b1;
               if (issue_ff < count_ff) begin
                  act_rd_en = 1'b1;
                  a_root_in = 1'b0;
                  issue_in  = issue_ff + CNT_W'(1);
               end else begin
                  a_root_in     = 1'b1;
                  issue_done_in = 1'b1;
               end
            end
            // Stage b: look up the child for this text character.
            if (a_valid_ff) begin
               link_ctl.rd_en = 1'b1;
               b_valid_in     = 1'b1;
            end
            // Stage c: a live child joins the list, compacted in place. The
            // write slot never passes the entries that are still to be read.
            if (b_valid_ff && in_alpha && (link_child != '0)) begin
               if (link_end) match_in = 1'b1;
               if (wr_cnt_ff < CNT_W'(MAX_WORD)) begin
                  act_wr_en = 1'b1;
                  wr_cnt_in = wr_cnt_ff + CNT_W'(1);
               end
            end
            if (srch_finish) begin
               result_in.matched     = match_ff;
               result_in.status      = STAT_OK;
               result_in.end_of_item = last_ff;
               count_in              = last_ff ? '0 : wr_cnt_ff;
               if (last_ff) match_in = 1'b0;
            end
         end
         S_REPORT: begin
            done = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         cursor_ff     <= '0;
         length_ff     <= '0;
         rejected_ff   <= 1'b0;
         code_ff       <= STAT_OK;
         nodes_used_ff <= (NODE_W+1)'(1);
         count_ff      <= '0;
         match_ff      <= 1'b0;
         issue_ff      <= '0;
         issue_done_ff <= 1'b0;
         wr_cnt_ff     <= '0;
         a_valid_ff    <= 1'b0;
         a_root_ff     <= 1'b0;
         b_valid_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         length_ff     <= length_in;
         rejected_ff   <= rejected_in;
         code_ff       <= code_in;
         nodes_used_ff <= nodes_used_in;
         count_ff      <= count_in;
         match_ff      <= match_in;
         issue_ff      <= issue_in;
         issue_done_ff <= issue_done_in;
         wr_cnt_ff     <= wr_cnt_in;
         a_valid_ff    <= a_valid_in;
         a_root_ff     <= a_root_in;
         b_valid_ff    <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff   <= char_in;
      last_ff   <= last_in;
      result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (act_wr_en) begin
         act_mem[act_wr_addr] <= act_wr_data;
      end
      if (act_rd_en) begin
         act_rdata_ff <= act_mem[act_rd_addr];
      end
   end

   assign result = result_ff;

endmodule

// ===== design/trie_substring_matcher_core.sv =====
// ============================================================================
// trie_substring_matcher_core
// Multi-pattern substring matcher over a character trie kept in memory.
// ============================================================================
// Usage: each request transfer carries one character. Opcode insert adds it
// to the pattern being built; last closes the pattern and marks its end.
// Opcode search feeds one text character; last closes the text and clears
// the partial matches and the sticky match flag after reporting.
// Every request gives exactly one response transfer, in order.
// In a search the single read port of the link memory serves one lookup
// per cycle: one for each partial match held (at most MAX_WORD) plus one
// for the root.
// One item is in work at a time; the next request is taken as soon as the
// previous result sits in the response register, even while it is stalled.
// A stalled response holds its register; the block then waits before
// reporting the next result.
// Reset: the link memory is swept to zero, one entry per cycle, over all
// NODES * 2**ceil(log2(ALPHABET)) entries (131072 by default); requests are
// not taken during the sweep.
module trie_substring_matcher_core import tsm_pkg::*; #(
   parameter int NODES    = NODES_DEFAULT,
   parameter int ALPHABET = ALPHABET_DEFAULT,
   parameter int MAX_WORD = MAX_WORD_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   tsm_req_if.sink       req_chan,
   tsm_rsp_if.source     rsp_chan
);

   localparam int NODE_W = $clog2(NODES);
   localparam int LA_W   = $clog2(NODES) + $clog2(ALPHABET);

   tsm_link_ctl_type   link_ctl;
   logic [LA_W-1:0]    link_rd_addr;
   logic [LA_W-1:0]    link_wr_addr;
   logic [NODE_W:0]    link_wr_data;
   logic [NODE_W:0]    link_rd_data;
   logic               clear_busy;
   logic               req_ready;
   logic               out_free;
   logic               done;
   tsm_result_type     result;

   logic               rsp_valid_ff, rsp_valid_in;
   tsm_result_type     rsp_data_ff, rsp_data_in;

   tsm_link_store #(
      .NODES    (NODES),
      .ALPHABET (ALPHABET)
   ) u_link_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (link_ctl),
      .rd_addr    (link_rd_addr),
      .wr_addr    (link_wr_addr),
      .wr_data    (link_wr_data),
      .rd_data    (link_rd_data),
      .clear_busy (clear_busy)
   );

   tsm_ctrl #(
      .NODES    (NODES),
      .ALPHABET (ALPHABET),
      .MAX_WORD (MAX_WORD)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_opcode    (req_chan.opcode),
      .req_character (req_chan.character),
      .req_last      (req_chan.last),
      .req_ready     (req_ready),
      .out_free      (out_free),
      .done          (done),
      .result        (result),
      .link_ctl      (link_ctl),
      .link_rd_addr  (link_rd_addr),
      .link_wr_addr  (link_wr_addr),
      .link_wr_data  (link_wr_data),
      .link_rd_data  (link_rd_data),
      .clear_busy    (clear_busy)
   );

   assign req_chan.ready = req_ready;

   // Response register: free when empty or being taken in this cycle.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.matched     = rsp_data_ff.matched;
   assign rsp_chan.status      = rsp_data_ff.status;
   assign rsp_chan.end_of_item = rsp_data_ff.end_of_item;

endmodule

// ===== design/tsm_checker.sv =====
// ============================================================================
// tsm_checker
// Port-level checks of the matcher: response count against requests, stall
// hold of the response, hold-off right after reset and result field consistency.
// ============================================================================
module tsm_checker import tsm_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_matched,
   input logic [STATUS_BITS-1:0] rsp_status,
   input logic                   rsp_end_of_item
);

   // Requests taken whose response has not been transferred yet.
   logic [1:0] pend_ff, pend_in;

   always_comb begin
      pend_in = pend_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable({rsp_matched, rsp_status, rsp_end_of_item}))
      else $error("response changed while stalled");

   sweep_holdoff_a: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request taken right after reset");

   fields_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_matched && (rsp_status != STAT_OK)))
      else $error("response reports a match and an insert error together");

   no_orphan_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 2'd0))
      else $error("response without a pending request");

   pend_bound_a: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two requests in flight");

endmodule

bind trie_substring_matcher_core tsm_checker u_tsm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_matched     (rsp_chan.matched),
   .rsp_status      (rsp_chan.status),
   .rsp_end_of_item (rsp_chan.end_of_item)
);
